[rtl/lcw_pkg.sv]
package lcw_pkg;

  localparam int unsigned SampleW  = 24;
  localparam int unsigned SumW     = 28;
  localparam int unsigned WeightW  = 28;
  localparam int unsigned CntW     = 4;
  localparam int unsigned ScaleW   = 16;
  localparam int unsigned NumW     = 30;
  localparam int unsigned DenW     = ScaleW + 1;
  localparam int unsigned SamplesDefault = 10;

  localparam logic [ScaleW-1:0]  ScaleReset = 16'd880;
  localparam logic [SampleW-1:0] SignFlip   = 24'h800000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AVG,
    ST_DELTA,
    ST_SCALE,
    ST_WDIV,
    ST_EMIT
  } lcw_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } lcw_div_stat_t;

endpackage

[rtl/load_cell_tare_weigh.sv]
// a sample or tare request that does not close a window leaves the input ready
// a closing window runs an averaging pass of the bit-serial divider, delta and scale
// states and a second pass; a tare window stops after averaging, the dead zone skips
// the second pass; the next transfer is taken in the cycle after the result loads
// input is refused until then; a result waiting in the output register stalls it
// reset: sum, count, offset, last shown cleared, first window tares, scale 880
module load_cell_tare_weigh #(
  parameter int unsigned SAMPLES = lcw_pkg::SamplesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [23:0] sample
  input  logic [0:0]  s_axis_tuser,   // [0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [27:0] weight_tenths, [31:28] zero
  output logic [1:0]  m_axis_tuser    // [0] tared, [1] shown
);

  localparam int unsigned SampleW = lcw_pkg::SampleW;
  localparam int unsigned SumW    = lcw_pkg::SumW;
  localparam int unsigned WeightW = lcw_pkg::WeightW;
  localparam int unsigned CntW    = lcw_pkg::CntW;
  localparam int unsigned ScaleW  = lcw_pkg::ScaleW;
  localparam int unsigned NumW    = lcw_pkg::NumW;
  localparam int unsigned DenW    = lcw_pkg::DenW;
  localparam int unsigned FiveW   = SampleW + 3;
  localparam logic [CntW-1:0] SamplesC = CntW'(SAMPLES);

  lcw_pkg::lcw_state_e    state_q, state_d;
  lcw_pkg::lcw_div_stat_t div_stat;

  logic [ScaleW-1:0]  scale_q;
  logic [SumW-1:0]    sum_q, sum_next;
  logic [CntW-1:0]    cnt_q, cnt_next;
  logic [SampleW-1:0] offset_q;
  logic               tare_pend_q;
  logic [WeightW-1:0] last_q;
  logic               last_valid_q;
  logic [SampleW-1:0] delta_q;
  logic [FiveW-1:0]   five_q;
  logic [WeightW-1:0] res_weight_q;
  logic               res_tared_q;
  logic               out_valid_q;
  logic [WeightW-1:0] out_weight_q;
  logic               out_tared_q;
  logic               out_shown_q;

  logic               in_xfer;
  logic               win_done;
  logic               dead;
  logic               out_load;
  logic               shown;
  logic [ScaleW-1:0]  sc_eff;
  logic [SampleW-1:0] avg;
  logic               div_start;
  logic [NumW-1:0]    div_num;
  logic [DenW-1:0]    div_den;
  logic [NumW-1:0]    quot;

  assign s_axis_tready = (state_q == lcw_pkg::ST_IDLE);
  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign sum_next = sum_q + SumW'(s_axis_tdata ^ lcw_pkg::SignFlip);
  assign cnt_next = cnt_q + 1'b1;
  assign win_done = in_xfer && !s_axis_tuser[0] && (cnt_next == SamplesC);
  assign sc_eff   = (scale_q == '0) ? ScaleW'(1) : scale_q;
  assign avg      = quot[SampleW-1:0];
  // below 0.2 g when 5*delta < scale
  assign dead     = five_q < FiveW'(sc_eff);
  assign out_load = (state_q == lcw_pkg::ST_EMIT) && (!out_valid_q || m_axis_tready);
  assign shown    = !res_tared_q && (!last_valid_q || (res_weight_q != last_q));

  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    div_num   = {{(NumW - SumW){1'b0}}, sum_next};
    div_den   = DenW'(SAMPLES);
    case (state_q)
      lcw_pkg::ST_IDLE: begin
        if (win_done) begin
          div_start = 1'b1;
          state_d   = lcw_pkg::ST_AVG;
        end
      end
      lcw_pkg::ST_AVG: begin
        if (div_stat.done) begin
          state_d = tare_pend_q ? lcw_pkg::ST_EMIT : lcw_pkg::ST_DELTA;
        end
      end
      lcw_pkg::ST_DELTA: begin
        state_d = lcw_pkg::ST_SCALE;
      end
      lcw_pkg::ST_SCALE: begin
        // (20*delta + scale) / (2*scale) rounds 10*delta/scale to nearest
        div_num = NumW'({five_q, 2'b00}) + NumW'(sc_eff);
        div_den = {sc_eff, 1'b0};
        if (dead) begin
          state_d = lcw_pkg::ST_EMIT;
        end else begin
          div_start = 1'b1;
          state_d   = lcw_pkg::ST_WDIV;
        end
      end
      lcw_pkg::ST_WDIV: begin
        if (div_stat.done) begin
          state_d = lcw_pkg::ST_EMIT;
        end
      end
      lcw_pkg::ST_EMIT: begin
        if (out_load) begin
          state_d = lcw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lcw_pkg::ST_IDLE;
      end
    endcase
  end

  lcw_div_serial #(
    .NW(NumW),
    .DW(DenW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_num),
    .divisor_i (div_den),
    .quot_o    (quot),
    .stat_o    (div_stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= lcw_pkg::ST_IDLE;
      scale_q      <= lcw_pkg::ScaleReset;
      sum_q        <= '0;
      cnt_q        <= '0;
      offset_q     <= '0;
      tare_pend_q  <= 1'b1;
      last_q       <= '0;
      last_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        scale_q <= cfg_wdata_i;
      end
      if (in_xfer) begin
        if (s_axis_tuser[0] || win_done) begin
          sum_q <= '0;
          cnt_q <= '0;
        end else begin
          sum_q <= sum_next;
          cnt_q <= cnt_next;
        end
        if (s_axis_tuser[0]) begin
          tare_pend_q  <= 1'b1;
          last_valid_q <= 1'b0;
        end
      end
      if (state_q == lcw_pkg::ST_AVG && div_stat.done && tare_pend_q) begin
        offset_q     <= avg;
        tare_pend_q  <= 1'b0;
        last_valid_q <= 1'b0;
      end
      if (out_load && shown) begin
        last_q       <= res_weight_q;
        last_valid_q <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == lcw_pkg::ST_AVG && div_stat.done) begin
      delta_q      <= (avg > offset_q) ? (avg - offset_q) : '0;
      res_weight_q <= '0;
      res_tared_q  <= tare_pend_q;
    end
    if (state_q == lcw_pkg::ST_DELTA) begin
      five_q <= {1'b0, delta_q, 2'b00} + FiveW'(delta_q);
    end
    if (state_q == lcw_pkg::ST_WDIV && div_stat.done) begin
      res_weight_q <= quot[WeightW-1:0];
    end
    if (out_load) begin
      out_weight_q <= res_weight_q;
      out_tared_q  <= res_tared_q;
      out_shown_q  <= shown;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(32 - WeightW){1'b0}}, out_weight_q};
  assign m_axis_tuser  = {out_shown_q, out_tared_q};

  // input is only taken while the divider is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !div_stat.busy)
    else $error("input ready while divider busy");

  // a divider result only arrives in a state that waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == lcw_pkg::ST_AVG || state_q == lcw_pkg::ST_WDIV))
    else $error("divider done outside a wait state");

  // a tare window carries zero weight and is never shown
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0 && !m_axis_tuser[1]))
    else $error("tare result with weight or shown flag");

  // the window counter is cleared when it reaches the window length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q < SamplesC)
    else $error("window count reached window length");

endmodule

[rtl/lcw_div_serial.sv]
module lcw_div_serial #(
  parameter int unsigned NW = lcw_pkg::NumW,
  parameter int unsigned DW = lcw_pkg::DenW
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [NW-1:0]         dividend_i,
  input  logic [DW-1:0]         divisor_i,
  output logic [NW-1:0]         quot_o,
  output lcw_pkg::lcw_div_stat_t stat_o
);

  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0] num_q, num_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [DW-1:0] den_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [DW:0]   shifted;
  logic [DW:0]   diff;
  logic          ge;

  // one restoring step per cycle, quotient bits shift in behind the dividend
  always_comb begin
    shifted = {rem_q, num_q[NW-1]};
    diff    = shifted - {1'b0, den_q};
    ge      = shifted >= {1'b0, den_q};
    num_d   = num_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      num_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = CW'(NW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[NW-2:0], ge};
      rem_d = ge ? diff[DW-1:0] : shifted[DW-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= divisor_i;
    end
  end

  assign quot_o      = num_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

[dv/load_cell_tare_weigh_tb.sv]
`timescale 1ns / 1ps

module load_cell_tare_weigh_tb;
  import lcw_pkg::*;

  localparam int unsigned Samples      = SamplesDefault;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned SettleCycles = 100;
  localparam int unsigned QuietLimit   = 4000;
  localparam longint      CodeMax      = 64'hFF_FFFF;

  typedef enum logic {
    MODE_SAMPLE = 1'b0,
    MODE_TARE   = 1'b1
  } weigh_mode_e;

  // shapes of a random window relative to the stored zero
  typedef enum int {
    WIN_BELOW,
    WIN_DEADBAND,
    WIN_ROUNDING,
    WIN_WIDE,
    WIN_REPEAT,
    WIN_SMALL
  } window_kind_e;

  typedef struct packed {
    logic [WeightW-1:0] weight;
    logic               tared;
    logic               shown;
  } weigh_res_t;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [15:0]       cfg_wdata_i;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [23:0]       s_axis_tdata;   // [23:0] sample
  logic [0:0]        s_axis_tuser;   // [0] mode
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [31:0]       m_axis_tdata;   // [27:0] weight_tenths, [31:28] zero
  logic [1:0]        m_axis_tuser;   // [0] tared, [1] shown

  // weighing state as the block should hold it
  logic [ScaleW-1:0]  scale_q;
  logic [SumW-1:0]    sum_q;
  logic [CntW-1:0]    count_q;
  logic [SampleW-1:0] offset_q;
  logic               tare_pend_q;
  logic [WeightW-1:0] last_shown_q;
  logic               shown_valid_q;

  weigh_res_t expected_weights[$];

  int     src_idle_pct;
  int     sink_idle_pct;
  int     hold_requests;
  int     mismatch_count;
  int     quiet_cycles;
  longint last_target;

  load_cell_tare_weigh uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic void weigh_sample(weigh_mode_e mode, logic [SampleW-1:0] raw);
    logic [SampleW-1:0] code;
    logic [SampleW-1:0] avg;
    longint unsigned    delta;
    longint unsigned    sc;
    logic [WeightW-1:0] w;
    weigh_res_t         res;
    if (mode == MODE_TARE) begin
      sum_q         = '0;
      count_q       = '0;
      tare_pend_q   = 1'b1;
      shown_valid_q = 1'b0;
      return;
    end
    code    = raw ^ SignFlip;
    sum_q   = sum_q + SumW'(code);
    count_q = count_q + 1'b1;
    if (count_q < Samples) return;
    avg     = SampleW'(sum_q / Samples);
    sum_q   = '0;
    count_q = '0;
    if (tare_pend_q) begin
      offset_q      = avg;
      tare_pend_q   = 1'b0;
      shown_valid_q = 1'b0;
      res = '{weight: '0, tared: 1'b1, shown: 1'b0};
    end else begin
      sc = (scale_q == '0) ? 1 : longint'(scale_q);
      if (avg <= offset_q) begin
        w = '0;
      end else begin
        delta = longint'(avg - offset_q);
        // dead zone below two tenths of a gram
        if (5 * delta < sc) w = '0;
        else w = WeightW'((20 * delta + sc) / (2 * sc));
      end
      res = '{weight: w, tared: 1'b0, shown: 1'b0};
      if (!shown_valid_q || w != last_shown_q) begin
        last_shown_q  = w;
        shown_valid_q = 1'b1;
        res.shown     = 1'b1;
      end
    end
    expected_weights.push_back(res);
  endfunction

  function automatic logic [SampleW-1:0] clamp_code(longint v);
    if (v < 0) return '0;
    if (v > CodeMax) return SampleW'(CodeMax);
    return SampleW'(v);
  endfunction

  // tvalid is left high after a transfer; the next call or a gap decides its value
  task automatic send_item(weigh_mode_e mode, logic [SampleW-1:0] raw);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= raw;
    s_axis_tuser  <= mode;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    weigh_sample(mode, raw);
  endtask

  task automatic settle_block();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_weights.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_scale(logic [ScaleW-1:0] value);
    settle_block();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    scale_q = value;
  endtask

  // mostly whole windows aimed at chosen points around the zero, some tare noise
  task automatic run_windows(int n_items);
    int           sent;
    int           pick;
    window_kind_e kind;
    longint       sc;
    longint       target;
    longint       amp;
    longint       noise;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 5) begin
        send_item(MODE_TARE, SampleW'($urandom));
        sent++;
      end
      sc   = (scale_q == '0) ? 1 : longint'(scale_q);
      pick = $urandom_range(0, 99);
      if (pick < 10) kind = WIN_BELOW;
      else if (pick < 25) kind = WIN_DEADBAND;
      else if (pick < 45) kind = WIN_ROUNDING;
      else if (pick < 55) kind = WIN_WIDE;
      else if (pick < 75) kind = WIN_REPEAT;
      else kind = WIN_SMALL;
      case ($urandom_range(0, 3))
        0: amp = 0;
        1: amp = 3;
        2: amp = 500;
        default: amp = 50000;
      endcase
      if (tare_pend_q) begin
        if ($urandom_range(0, 1) == 0) target = longint'($urandom_range(0, 32'hFF_FFFF));
        else target = 64'h80_0000 + longint'($urandom_range(0, 200000)) - 100000;
      end else begin
        case (kind)
          WIN_BELOW:    target = longint'(offset_q) - longint'($urandom_range(0, 2000));
          WIN_DEADBAND: target = longint'(offset_q) + sc / 5 + longint'($urandom_range(0, 2)) - 1;
          WIN_ROUNDING: target = longint'(offset_q)
                                 + ((2 * longint'($urandom_range(0, 40)) + 1) * sc) / 20
                                 + longint'($urandom_range(0, 2)) - 1;
          WIN_WIDE:     target = longint'(offset_q)
                                 + longint'($urandom_range(0, 32'hFF_FFFF));
          WIN_REPEAT:   target = last_target;
          default:      target = longint'(offset_q)
                                 + longint'($urandom_range(0, int'(30 * sc)));
        endcase
        // exact averages where the boundary or the repeat matters
        if (kind inside {WIN_DEADBAND, WIN_ROUNDING, WIN_REPEAT}) amp = 0;
      end
      last_target = target;
      for (int i = 0; i < Samples; i++) begin
        if ($urandom_range(0, 299) == 0) begin
          send_item(MODE_TARE, SampleW'($urandom));
          sent++;
          break;
        end
        noise = (amp == 0) ? 0 : longint'($urandom_range(0, int'(2 * amp))) - amp;
        send_item(MODE_SAMPLE, clamp_code(target + noise) ^ SignFlip);
        sent++;
      end
    end
  endtask

  task automatic test_directed_window();
    // a partial window with the extreme codes is dropped by the tare request
    send_item(MODE_SAMPLE, 24'h800000);
    send_item(MODE_SAMPLE, 24'h7FFFFF);
    send_item(MODE_SAMPLE, 24'hFFFFFF);
    send_item(MODE_TARE, 24'hFFFFFF);
    // first full window after reset sets the zero at mid code
    repeat (Samples) send_item(MODE_SAMPLE, 24'h000000);
    // full-scale load at the reset scale
    repeat (Samples) send_item(MODE_SAMPLE, 24'h7FFFFF);
  endtask

  task automatic test_scale_extremes();
    // a zero register divides as one
    logic [ScaleW-1:0] scales[3] = '{16'd1, 16'd0, 16'hFFFF};
    foreach (scales[i]) begin
      write_scale(scales[i]);
      run_windows(150);
    end
  endtask

  task automatic test_random_weighing(int n_items);
    if ($urandom_range(0, 3) == 0) write_scale(ScaleW'($urandom_range(1, 65535)));
    else write_scale(ScaleW'($urandom_range(200, 4000)));
    run_windows(n_items);
  endtask

  task automatic test_backpressure();
    write_scale(ScaleReset);
    repeat (2) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
      hold_requests++;
      @(posedge clk_i);
      run_windows(80);
    end
  endtask

  initial begin : drain
    int served;
    served = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_requests != served) begin
        served++;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  always @(posedge clk_i) begin : check_result
    weigh_res_t exp_res;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_weights.size() == 0) begin
        $error("unexpected result transfer: weight_tenths %0d tared %0d shown %0d",
               m_axis_tdata[WeightW-1:0], m_axis_tuser[0], m_axis_tuser[1]);
        mismatch_count++;
      end else begin
        exp_res = expected_weights.pop_front();
        if (m_axis_tdata[WeightW-1:0] !== exp_res.weight) begin
          $error("weight_tenths: expected %0d, got %0d", exp_res.weight,
                 m_axis_tdata[WeightW-1:0]);
          mismatch_count++;
        end
        if (m_axis_tdata[31:WeightW] !== '0) begin
          $error("tdata pad: expected 0, got %0h", m_axis_tdata[31:WeightW]);
          mismatch_count++;
        end
        if (m_axis_tuser[0] !== exp_res.tared) begin
          $error("tared: expected %0d, got %0d", exp_res.tared, m_axis_tuser[0]);
          mismatch_count++;
        end
        if (m_axis_tuser[1] !== exp_res.shown) begin
          $error("shown: expected %0d, got %0d", exp_res.shown, m_axis_tuser[1]);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    scale_q        = ScaleReset;
    sum_q          = '0;
    count_q        = '0;
    offset_q       = '0;
    tare_pend_q    = 1'b1;
    last_shown_q   = '0;
    shown_valid_q  = 1'b0;
    hold_requests  = 0;
    last_target    = 0;
    src_idle_pct   = 9;
    sink_idle_pct  = 61;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_window();
    test_scale_extremes();

    src_idle_pct  = 61;
    sink_idle_pct = 9;
    test_random_weighing(600);
    test_random_weighing(300);

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    test_random_weighing(500);
    test_backpressure();

    settle_block();
    if (mismatch_count == 0 && expected_weights.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[files.f]
rtl/lcw_pkg.sv
rtl/lcw_div_serial.sv
rtl/load_cell_tare_weigh.sv
dv/load_cell_tare_weigh_tb.sv
